// ===== sv/tli_pkg.sv =====
// Shared types and constants for the trilinear interpolator.
package tli_pkg;

  localparam int NUM_CORNERS = 8;
  localparam int AVG_SHIFT   = 3;

  typedef struct packed {
    logic diff;
    logic mul;
    logic add;
  } tli_ld_t;

endpackage

// ===== sv/trilinear_interpolator_unit.sv =====
// Top level of the pipelined trilinear interpolator with stream handshakes.
// Throughput: one transaction per cycle while the output is not stalled; each of
// the three lerp passes spends three register stages (difference, multiply, add)
// after one input stage.
// A stalled output holds the pipeline; empty stages still take new transactions.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
module trilinear_interpolator_unit import tli_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // Fields from bit 0: corner_000, corner_100, corner_010, corner_110, corner_001,
  // corner_101, corner_011, corner_111, frac_x, frac_y, frac_z, zero padding.
  input  logic [((NUM_CORNERS*SAMPLE_BITS + 3*(FRAC_BITS+2) + 7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // Fields from bit 0: interp_value, zero padding.
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] out_tdata,
  // Fields from bit 0: out_of_range.
  output logic out_tuser
);

  localparam int SB    = SAMPLE_BITS;
  localparam int FB    = FRAC_BITS;
  localparam int PW    = FB + 2;
  localparam int OUT_W = ((SB + 7) / 8) * 8;
  localparam int SUM_W = SB + AVG_SHIFT;
  localparam int NSTG  = 10;

  logic [NSTG:0]   rdy;
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] v_src;

  logic signed [SB-1:0] c_in [NUM_CORNERS];
  logic [PW-1:0]        f_in [3];
  logic [2:0]           f_ok;

  logic signed [SB-1:0] c0_r [NUM_CORNERS];
  logic [FB:0]          tx0_r;
  logic [FB:0]          ty_r [4];
  logic [FB:0]          tz_r [7];
  logic                 bad_r [NSTG];

  logic signed [SB:0]      s1_r [4];
  logic signed [SB+1:0]    s2_r [2];
  logic signed [SUM_W-1:0] s3_r;
  logic signed [SB-1:0]    avg_r [4:NSTG-1];

  logic signed [SB-1:0] xa [4];
  logic signed [SB-1:0] xb [4];
  logic signed [SB-1:0] ex [4];
  logic signed [SB-1:0] ya [2];
  logic signed [SB-1:0] yb [2];
  logic signed [SB-1:0] fy [2];
  logic signed [SB-1:0] za [1];
  logic signed [SB-1:0] zb [1];
  logic signed [SB-1:0] rz [1];

  always_comb begin
    rdy[NSTG] = out_tready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_src = {v_r[NSTG-2:0], in_tvalid};
    for (int k = 0; k < NSTG; k++) begin
      v_nxt[k] = rdy[k] ? v_src[k] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready = rdy[0];

  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      c_in[i] = in_tdata[i*SB +: SB];
    end
    for (int j = 0; j < 3; j++) begin
      f_in[j] = in_tdata[NUM_CORNERS*SB + j*PW +: PW];
      f_ok[j] = !f_in[j][PW-1] && (!f_in[j][FB] || (f_in[j][FB-1:0] == '0));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      c0_r     <= c_in;
      tx0_r    <= f_in[0][FB:0];
      ty_r[0]  <= f_in[1][FB:0];
      tz_r[0]  <= f_in[2][FB:0];
      bad_r[0] <= !(&f_ok);
    end
    for (int k = 1; k < 4; k++) begin
      if (rdy[k]) begin
        ty_r[k] <= ty_r[k-1];
      end
    end
    for (int k = 1; k < 7; k++) begin
      if (rdy[k]) begin
        tz_r[k] <= tz_r[k-1];
      end
    end
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) begin
        bad_r[k] <= bad_r[k-1];
      end
    end
    if (rdy[1]) begin
      for (int i = 0; i < 4; i++) begin
        s1_r[i] <= {c0_r[2*i][SB-1], c0_r[2*i]} + {c0_r[2*i+1][SB-1], c0_r[2*i+1]};
      end
    end
    if (rdy[2]) begin
      for (int i = 0; i < 2; i++) begin
        s2_r[i] <= {s1_r[2*i][SB], s1_r[2*i]} + {s1_r[2*i+1][SB], s1_r[2*i+1]};
      end
    end
    if (rdy[3]) begin
      s3_r <= {s2_r[0][SB+1], s2_r[0]} + {s2_r[1][SB+1], s2_r[1]};
    end
    if (rdy[4]) begin
      avg_r[4] <= s3_r[SUM_W-1:AVG_SHIFT];
    end
    for (int k = 5; k < NSTG; k++) begin
      if (rdy[k]) begin
        avg_r[k] <= avg_r[k-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      xa[i] = c0_r[2*i];
      xb[i] = c0_r[2*i+1];
    end
    ya[0] = ex[0];
    yb[0] = ex[1];
    ya[1] = ex[2];
    yb[1] = ex[3];
    za[0] = fy[0];
    zb[0] = fy[1];
  end

  tli_lerp #(.W(SB), .FB(FB), .LANES(4)) u_lerp_x (
    .clk (clk),
    .ld  ('{diff: rdy[1], mul: rdy[2], add: rdy[3]}),
    .a   (xa),
    .b   (xb),
    .t   (tx0_r),
    .y   (ex)
  );

  tli_lerp #(.W(SB), .FB(FB), .LANES(2)) u_lerp_y (
    .clk (clk),
    .ld  ('{diff: rdy[4], mul: rdy[5], add: rdy[6]}),
    .a   (ya),
    .b   (yb),
    .t   (ty_r[3]),
    .y   (fy)
  );

  tli_lerp #(.W(SB), .FB(FB), .LANES(1)) u_lerp_z (
    .clk (clk),
    .ld  ('{diff: rdy[7], mul: rdy[8], add: rdy[9]}),
    .a   (za),
    .b   (zb),
    .t   (tz_r[6]),
    .y   (rz)
  );

  assign out_tvalid = v_r[NSTG-1];
  assign out_tuser  = bad_r[NSTG-1];
  assign out_tdata  = OUT_W'({bad_r[NSTG-1] ? avg_r[NSTG-1] : rz[0]});

endmodule

// ===== sv/tli_lerp.sv =====
// Three-stage linear interpolation lanes: difference, multiply, floor-shift and add.
module tli_lerp import tli_pkg::*; #(
  parameter int W     = 16,
  parameter int FB    = 16,
  parameter int LANES = 4
) (
  input  logic                clk,
  input  tli_ld_t             ld,
  input  logic signed [W-1:0] a [LANES],
  input  logic signed [W-1:0] b [LANES],
  input  logic        [FB:0]  t,
  output logic signed [W-1:0] y [LANES]
);

  localparam int PROD_W = W + FB + 2;

  logic signed [W:0]        diff_r [LANES];
  logic signed [W-1:0]      a1_r   [LANES];
  logic        [FB:0]       t1_r;
  logic signed [PROD_W-1:0] prod_r [LANES];
  logic signed [W-1:0]      a2_r   [LANES];
  logic signed [W-1:0]      y_r    [LANES];
  logic signed [PROD_W:0]   prod_full [LANES];
  logic signed [W+1:0]      sum_full  [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      prod_full[i] = diff_r[i] * $signed({1'b0, t1_r});
      sum_full[i]  = {{2{a2_r[i][W-1]}}, a2_r[i]} + prod_r[i][PROD_W-1:FB];
    end
  end

  always_ff @(posedge clk) begin
    if (ld.diff) begin
      t1_r <= t;
      for (int i = 0; i < LANES; i++) begin
        diff_r[i] <= {b[i][W-1], b[i]} - {a[i][W-1], a[i]};
        a1_r[i]   <= a[i];
      end
    end
    if (ld.mul) begin
      for (int i = 0; i < LANES; i++) begin
        prod_r[i] <= prod_full[i][PROD_W-1:0];
        a2_r[i]   <= a1_r[i];
      end
    end
    if (ld.add) begin
      for (int i = 0; i < LANES; i++) begin
        y_r[i] <= sum_full[i][W-1:0];
      end
    end
  end

  assign y = y_r;

endmodule

// ===== sv/tli_checker.sv =====
// Port-level checker for the trilinear interpolator and its bind statement.
module tli_checker #(
  parameter int OUT_W = 16
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tuser
);

  // A waiting result is neither dropped nor changed.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled output transaction was lost or changed.");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Output valid after reset.");

  // With the output side ready, the whole pipeline advances, so input is ready.
  a_ready_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("Input not ready although the output side is ready.");

  // An empty pipeline stays empty when no input transaction arrives.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !in_tvalid && $past(!in_tvalid, 1) && $past(!in_tvalid, 2)
      && $past(!in_tvalid, 3) && $past(!in_tvalid, 4) && $past(!in_tvalid, 5)
      && $past(!in_tvalid, 6) && $past(!in_tvalid, 7) && $past(!in_tvalid, 8)
      && $past(!in_tvalid, 9) && $past(!in_tvalid, 10) && $past(rst_n, 10)
      |=> !out_tvalid)
    else $error("Output transaction appeared without an input transaction.");

endmodule

bind trilinear_interpolator_unit tli_checker #(.OUT_W(OUT_W)) u_tli_checker (.*);
